[rtl/md5_stream_hasher_top_defines.svh]
// ----------------------------------------------------------------------------
// md5 stream hasher assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_TOP_DEFINES_SVH
`define MD5_STREAM_HASHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MD5SH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("md5sh assertion failed");
// next-cycle implication
`define MD5SH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("md5sh assertion failed");
`else
`define MD5SH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MD5SH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/md5sh_pkg.sv]
// ----------------------------------------------------------------------------
// md5sh_pkg
// shared types, constants and a round helper function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package md5sh_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_PADZ,
    S_PADLEN,
    S_PREP,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_80,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      wr_byte;
    byte_src_t src;
    logic      count_len;
    logic      prep;
    logic      rnd_en;
    logic [5:0] rnd;
    logic      fold;
    logic      reinit;
    logic [1:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_56;
  } sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index for a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = i;
      2'd1:    g = i * 4'd5 + 4'd1;
      2'd2:    g = i * 4'd3 + 4'd5;
      default: g = i * 4'd7;
    endcase
    return g;
  endfunction

endpackage

[rtl/md5sh_ctrl.sv]
// ----------------------------------------------------------------------------
// md5sh_ctrl
// sequencer for byte intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "md5_stream_hasher_top_defines.svh"

module md5sh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_present,
  input  logic              in_end_of_message,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_word_number,
  output logic              out_last_word,
  output md5sh_pkg::cmd_t   cmd,
  input  md5sh_pkg::sts_t   sts
);

  md5sh_pkg::state_t state_r, state_nxt;
  md5sh_pkg::state_t ret_r, ret_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5sh_pkg::S_IDLE;
      ret_r   <= md5sh_pkg::S_IDLE;
      rnd_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    rnd_nxt      = rnd_r;
    wcnt_nxt     = wcnt_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.src      = md5sh_pkg::SRC_DATA;
    cmd.rnd      = rnd_r;
    cmd.word_sel = wcnt_r;
    case (state_r)
      md5sh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_present) begin
            cmd.wr_byte   = 1'b1;
            cmd.count_len = 1'b1;
          end
          if (in_byte_present && sts.pos_last) begin
            state_nxt = md5sh_pkg::S_PREP;
            ret_nxt   = in_end_of_message ? md5sh_pkg::S_PAD80 : md5sh_pkg::S_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = md5sh_pkg::S_PAD80;
          end
        end
      end
      md5sh_pkg::S_PAD80: begin
        cmd.wr_byte = 1'b1;
        cmd.src     = md5sh_pkg::SRC_80;
        if (sts.pos_last) begin
          state_nxt = md5sh_pkg::S_PREP;
          ret_nxt   = md5sh_pkg::S_PADZ;
        end else begin
          state_nxt = md5sh_pkg::S_PADZ;
        end
      end
      md5sh_pkg::S_PADZ: begin
        if (sts.pos_56) begin
          state_nxt = md5sh_pkg::S_PADLEN;
        end else begin
          cmd.wr_byte = 1'b1;
          cmd.src     = md5sh_pkg::SRC_ZERO;
          if (sts.pos_last) begin
            state_nxt = md5sh_pkg::S_PREP;
            ret_nxt   = md5sh_pkg::S_PADZ;
          end
        end
      end
      md5sh_pkg::S_PADLEN: begin
        cmd.wr_byte = 1'b1;
        cmd.src     = md5sh_pkg::SRC_LEN;
        if (sts.pos_last) begin
          state_nxt = md5sh_pkg::S_PREP;
          ret_nxt   = md5sh_pkg::S_OUT;
        end
      end
      md5sh_pkg::S_PREP: begin
        cmd.prep  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = md5sh_pkg::S_ROUND;
      end
      md5sh_pkg::S_ROUND: begin
        cmd.rnd_en = 1'b1;
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = md5sh_pkg::S_FOLD;
        end
      end
      md5sh_pkg::S_FOLD: begin
        cmd.fold  = 1'b1;
        wcnt_nxt  = '0;
        state_nxt = ret_r;
      end
      md5sh_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          wcnt_nxt = wcnt_r + 2'd1;
          if (wcnt_r == 2'd3) begin
            cmd.reinit = 1'b1;
            state_nxt  = md5sh_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = md5sh_pkg::S_IDLE;
      end
    endcase
  end

  assign out_word_number = wcnt_r;
  assign out_last_word   = (wcnt_r == 2'd3);

  `MD5SH_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `MD5SH_ASSERT_NEXT(a_rnd_step, clk, rst_n, (state_r == md5sh_pkg::S_ROUND && rnd_r != 6'd63), (state_r == md5sh_pkg::S_ROUND && rnd_r == $past(rnd_r) + 6'd1))
  `MD5SH_ASSERT_NEXT(a_fold_after, clk, rst_n, (state_r == md5sh_pkg::S_ROUND && rnd_r == 6'd63), (state_r == md5sh_pkg::S_FOLD))

endmodule

[rtl/md5sh_dp.sv]
// ----------------------------------------------------------------------------
// md5sh_dp
// block buffer, bit length, chaining words and one-round-per-cycle unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5sh_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      data_byte,
  input  md5sh_pkg::cmd_t cmd,
  output md5sh_pkg::sts_t sts,
  output logic [31:0]     digest_word
);

  logic [31:0] m_r [16];
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] pre_r;
  logic [63:0] len_r;
  logic [5:0]  pos_r;

  logic [7:0]  wbyte;
  logic [5:0]  pre_idx;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] new_b;

  always_comb begin
    case (cmd.src)
      md5sh_pkg::SRC_DATA: wbyte = data_byte;
      md5sh_pkg::SRC_80:   wbyte = md5sh_pkg::PAD_BYTE;
      md5sh_pkg::SRC_ZERO: wbyte = 8'h00;
      default:             wbyte = len_r[{pos_r[2:0], 3'b000} +: 8];
    endcase
  end

  // round function
  always_comb begin
    case (cmd.rnd[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum   = a_r + f + pre_r;
    dbl   = {sum, sum} << md5sh_pkg::ROT_TAB[{cmd.rnd[5:4], cmd.rnd[1:0]}];
    new_b = b_r + dbl[63:32];
  end

  // constant plus message word, fetched one round ahead
  assign pre_idx = cmd.prep ? 6'd0 : cmd.rnd + 6'd1;

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      m_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= wbyte;
    end
    pre_r <= md5sh_pkg::K_TAB[pre_idx] + m_r[md5sh_pkg::msg_index(pre_idx)];
    if (cmd.prep) begin
      a_r <= ch_r[0];
      b_r <= ch_r[1];
      c_r <= ch_r[2];
      d_r <= ch_r[3];
    end else if (cmd.rnd_en) begin
      a_r <= d_r;
      b_r <= new_b;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int k = 0; k < 4; k++) begin
        ch_r[k] <= md5sh_pkg::IV[k];
      end
      len_r <= '0;
      pos_r <= '0;
    end else begin
      if (cmd.wr_byte) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.count_len) begin
        len_r <= len_r + 64'd8;
      end
      if (cmd.fold) begin
        ch_r[0] <= ch_r[0] + a_r;
        ch_r[1] <= ch_r[1] + b_r;
        ch_r[2] <= ch_r[2] + c_r;
        ch_r[3] <= ch_r[3] + d_r;
      end
    end
  end

  assign sts.pos_last = (pos_r == 6'd63);
  assign sts.pos_56   = (pos_r == 6'd56);
  assign digest_word  = ch_r[cmd.word_sel];

endmodule

[rtl/md5_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// md5_stream_hasher_top
// streaming md5 digest: one message byte per word in, four digest words out
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  in      | in_valid/in_ready, in_data_byte, in_byte_present,| into block
//          | in_end_of_message                              |
//  out     | out_valid/out_ready, out_digest_word,          | out of block
//          | out_word_number, out_last_word                 |
//
//  each byte word is taken at once while the 64-byte buffer is filling
//  the 64th byte starts compression, input held off: a prefetch step, 64
//  rounds and a fold step through the single round unit; end of message
//  pads one byte per cycle (not in compressions or on the step to the length
//  bytes) and one or two compressions, then four digest words held till taken
//  synchronous active-low reset loads the initial chaining words, no sweep
//  out_ready low stalls only the digest output, input stays blocked meanwhile
`timescale 1ns / 1ps

module md5_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_number,
  output logic        out_last_word
);

  // command and status between sequencer and datapath
  md5sh_pkg::cmd_t cmd;
  md5sh_pkg::sts_t sts;

  md5sh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_word_number   (out_word_number),
    .out_last_word     (out_last_word),
    .cmd               (cmd),
    .sts               (sts)
  );

  md5sh_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_digest_word)
  );

endmodule
